@@ rtl/core/bbf_pkg.sv @@
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared constants, codes and types of the box blur filter.
// ----------------------------------------------------------------------------
package bbf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 15;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 13;
  localparam int WS_W    = 4;
  localparam int IW_W    = 11;
  localparam int IH_W    = 13;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  localparam logic [WS_W-1:0]  RST_WINDOW = 4'd3;
  localparam logic [IW_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [IH_W-1:0]  RST_HEIGHT = 13'd480;
  localparam logic [PIX_W-1:0] RST_BORDER = 8'd48;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CIDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_BORDER = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FLUSH,
    ST_DIV,
    ST_DONE
  } bbf_state_t;

endpackage

@@ rtl/core/bbf_fifo.sv @@
// ----------------------------------------------------------------------------
// bbf_fifo
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module bbf_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wptr <= ~wptr;
      end
      if (pop && pop_valid) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push && push_ready) - 2'(pop && pop_valid);
    end
  end

endmodule

@@ rtl/core/bbf_front.sv @@
// ----------------------------------------------------------------------------
// bbf_front
// Accepts items, tracks input and output raster positions, queues work.
// ----------------------------------------------------------------------------
module bbf_front import bbf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int COL_W      = 10,
  parameter int WCNT_W     = 11,
  parameter int SLOT_W     = 4,
  parameter int SZ_W       = 4,
  parameter int ENT_W      = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [WCNT_W-1:0] w_eff,
  input  logic [IH_W-1:0]   h_eff,
  input  logic [SZ_W-1:0]   reach,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [PIX_W-1:0]  pixel_in,
  input  logic              q_ready,
  output logic              q_push,
  output logic [ENT_W-1:0]  q_data
);

  localparam int LIN_W = ROW_W + COL_W + 1;

  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [SLOT_W-1:0] in_slot;
  logic [LIN_W-1:0]  lin;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [SLOT_W-1:0] out_slot;

  logic             accept;
  logic             input_done;
  logic             is_pixel;
  logic             emit;
  logic             eor;
  logic             eof;
  logic             in_eor;
  logic [LIN_W-1:0] thr;

  assign thr        = LIN_W'(32'(reach) * 32'(w_eff) + 32'(reach));
  assign input_done = (in_row >= h_eff);
  assign is_pixel   = (command == CMD_PIXEL) && !input_done;
  assign emit       = is_pixel ? (lin >= thr) : (input_done && (out_row < h_eff));
  assign eor        = (32'(out_col) + 32'd1) >= 32'(w_eff);
  assign eof        = eor && ((32'(out_row) + 32'd1) >= 32'(h_eff));
  assign in_eor     = (32'(in_col) + 32'd1) >= 32'(w_eff);

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (is_pixel || emit);
  assign q_data   = {is_pixel, pixel_in, in_slot, in_col, emit,
                     out_row, out_col, out_slot, eor, eof};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      lin      <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
    end else if (accept) begin
      if (emit && eof) begin
        in_row   <= '0;
        in_col   <= '0;
        in_slot  <= '0;
        lin      <= '0;
        out_row  <= '0;
        out_col  <= '0;
        out_slot <= '0;
      end else begin
        if (is_pixel) begin
          lin <= lin + LIN_W'(1);
          if (in_eor) begin
            in_col  <= '0;
            in_row  <= in_row + ROW_W'(1);
            in_slot <= (32'(in_slot) == MAX_WINDOW - 1) ? '0 : in_slot + SLOT_W'(1);
          end else begin
            in_col <= in_col + COL_W'(1);
          end
        end
        if (emit) begin
          if (eor) begin
            out_col  <= '0;
            out_row  <= out_row + ROW_W'(1);
            out_slot <= (32'(out_slot) == MAX_WINDOW - 1) ? '0 : out_slot + SLOT_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

@@ rtl/core/bbf_back.sv @@
// ----------------------------------------------------------------------------
// bbf_back
// Line store, window sweep, divider and output register.
// ----------------------------------------------------------------------------
module bbf_back import bbf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int COL_W      = 10,
  parameter int WCNT_W     = 11,
  parameter int SLOT_W     = 4,
  parameter int SZ_W       = 4,
  parameter int ENT_W      = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SZ_W-1:0]   size,
  input  logic [SZ_W-1:0]   reach,
  input  logic [WCNT_W-1:0] w_eff,
  input  logic [IH_W-1:0]   h_eff,
  input  logic [PIX_W-1:0]  border,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic [ENT_W-1:0]  q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              end_of_row,
  output logic              end_of_frame
);

  localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int DIV_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int CNT_W  = $clog2(SUM_W + 1);
  localparam int K_W    = ROW_W + 2;
  localparam int L_W    = ((COL_W > SZ_W) ? COL_W : SZ_W) + 2;

  logic [PIX_W-1:0] mem [DEPTH];

  logic              e_wr;
  logic [PIX_W-1:0]  e_pix;
  logic [SLOT_W-1:0] e_wslot;
  logic [COL_W-1:0]  e_wcol;
  logic              e_emit;
  logic [ROW_W-1:0]  e_orow;
  logic [COL_W-1:0]  e_ocol;
  logic [SLOT_W-1:0] e_oslot;
  logic              e_eor;
  logic              e_eof;

  assign {e_wr, e_pix, e_wslot, e_wcol, e_emit, e_orow, e_ocol, e_oslot, e_eor, e_eof} = q_data;

  bbf_state_t state, state_next;

  logic [K_W-1:0]    k;
  logic [L_W-1:0]    l;
  logic [L_W-1:0]    l_start;
  logic [SLOT_W-1:0] slot;
  logic [SZ_W-1:0]   dk;
  logic [SZ_W-1:0]   dl;
  logic [SZ_W-1:0]   span_m1;
  logic              eor;
  logic              eof;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_acc;
  logic [PIX_W-1:0]  rd_data;
  logic              rd_use;
  logic              rd_in;
  logic              inframe;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [SUM_W-1:0]  quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  dvs;
  logic [CNT_W-1:0]  cnt;
  logic              load_out;

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign span_m1 = SZ_W'({reach, 1'b0});
  assign dvs     = DIV_W'(32'(size) * 32'(size));
  assign waddr   = ADDR_W'(32'(e_wslot) * MAX_WIDTH + 32'(e_wcol));
  assign raddr   = ADDR_W'(32'(slot) * MAX_WIDTH + 32'(l[COL_W-1:0]));
  assign inframe = !k[K_W-1] && (k[K_W-2:0] < {1'b0, h_eff}) &&
                   !l[L_W-1] && (32'(l[L_W-2:0]) < 32'(w_eff));
  assign sum_acc = rd_use ? (sum + SUM_W'(rd_in ? rd_data : border)) : sum;
  assign trial   = {rem, quo[SUM_W-1]};
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (q_pop && e_wr) begin
      mem[waddr] <= e_pix;
    end
    if (state == ST_READ && inframe) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_pop && e_emit) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (dl == span_m1 && dk == span_m1) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_DIV;
      ST_DIV: begin
        if (32'(cnt) == SUM_W - 1) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_use <= 1'b0;
    end else begin
      rd_use <= (state == ST_READ);
    end
    rd_in <= inframe;
    case (state)
      ST_IDLE: begin
        k       <= K_W'(e_orow) - K_W'(reach);
        l_start <= L_W'(e_ocol) - L_W'(reach);
        l       <= L_W'(e_ocol) - L_W'(reach);
        slot    <= (32'(e_oslot) >= 32'(reach)) ? e_oslot - SLOT_W'(reach)
                 : SLOT_W'(32'(e_oslot) + MAX_WINDOW - 32'(reach));
        dk      <= '0;
        dl      <= '0;
        sum     <= '0;
        eor     <= e_eor;
        eof     <= e_eof;
      end
      ST_READ: begin
        sum <= sum_acc;
        if (dl == span_m1) begin
          dl   <= '0;
          l    <= l_start;
          dk   <= dk + SZ_W'(1);
          k    <= k + K_W'(1);
          slot <= (32'(slot) == MAX_WINDOW - 1) ? '0 : slot + SLOT_W'(1);
        end else begin
          dl <= dl + SZ_W'(1);
          l  <= l + L_W'(1);
        end
      end
      ST_FLUSH: begin
        quo <= sum_acc;
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        cnt <= cnt + CNT_W'(1);
        if (trial >= {1'b0, dvs}) begin
          rem <= DIV_W'(trial - {1'b0, dvs});
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_W-1:0];
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      pixel_out    <= quo[PIX_W-1:0];
      end_of_row   <= eor;
      end_of_frame <= eof;
    end
  end

endmodule

@@ rtl/core/box_blur_filter.sv @@
// ----------------------------------------------------------------------------
// box_blur_filter
// Streaming box blur of an 8-bit grayscale frame in raster order.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): command and pixel_in. A pixel command
// stores the pixel; a drain command flushes pending outputs after the last
// pixel of the frame. Each item yields at most one output item.
// Output channel (out_valid/out_ready): pixel_out, end_of_row, end_of_frame.
// Configuration: cfg_we, cfg_index, cfg_data; any write restarts the frame.
// Items pass a two-entry queue to the back end, so the input keeps flowing
// while a result waits for out_ready. A pixel that yields no output is only
// written to the line store. An item that yields an output is processed in
// the back end by one line store read per in-frame window position (border
// value elsewhere), then a bit-serial divide by size squared over SUM_W bits
// (SUM_W = 16 by default); the back end takes no new item until it is done.
// Reset restores the register defaults (3, 640, 480, 48) and clears all
// positions; line store contents are undefined until written.
// When the receiver stalls, the back end holds the finished result, then the
// queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module box_blur_filter import bbf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [PIX_W-1:0]  pixel_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              end_of_row,
  output logic              end_of_frame
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SZ_W   = $clog2(MAX_WINDOW + 1);
  localparam int ENT_W  = 1 + PIX_W + SLOT_W + COL_W + 1 + ROW_W + COL_W + SLOT_W + 2;

  logic [WS_W-1:0]  window_size;
  logic [IW_W-1:0]  image_width;
  logic [IH_W-1:0]  image_height;
  logic [PIX_W-1:0] border_value;

  logic [SZ_W-1:0]   size;
  logic [SZ_W-1:0]   reach;
  logic [WCNT_W-1:0] w_eff;
  logic [IH_W-1:0]   h_eff;

  logic             q_push;
  logic             q_ready;
  logic [ENT_W-1:0] q_wdata;
  logic             q_pop;
  logic             q_valid;
  logic [ENT_W-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= RST_WINDOW;
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      border_value <= RST_BORDER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW: window_size  <= cfg_data[WS_W-1:0];
        REG_WIDTH:  image_width  <= cfg_data[IW_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[IH_W-1:0];
        REG_BORDER: border_value <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign size  = (window_size == '0) ? SZ_W'(1)
               : (32'(window_size) > MAX_WINDOW) ? SZ_W'(MAX_WINDOW) : SZ_W'(window_size);
  assign reach = (size - SZ_W'(1)) >> 1;
  assign w_eff = (image_width == '0) ? WCNT_W'(1)
               : (32'(image_width) > MAX_WIDTH) ? WCNT_W'(MAX_WIDTH) : WCNT_W'(image_width);
  assign h_eff = (image_height == '0) ? IH_W'(1) : image_height;

  bbf_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW), .COL_W(COL_W), .WCNT_W(WCNT_W),
    .SLOT_W(SLOT_W), .SZ_W(SZ_W), .ENT_W(ENT_W)
  ) u_front (
    .clk(clk), .rst(rst), .restart(cfg_we), .w_eff(w_eff), .h_eff(h_eff),
    .reach(reach), .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .pixel_in(pixel_in), .q_ready(q_ready), .q_push(q_push), .q_data(q_wdata)
  );

  bbf_fifo #(.DATA_W(ENT_W)) u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_wdata), .push_ready(q_ready),
    .pop(q_pop), .pop_valid(q_valid), .pop_data(q_rdata)
  );

  bbf_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW), .COL_W(COL_W), .WCNT_W(WCNT_W),
    .SLOT_W(SLOT_W), .SZ_W(SZ_W), .ENT_W(ENT_W)
  ) u_back (
    .clk(clk), .rst(rst), .size(size), .reach(reach), .w_eff(w_eff), .h_eff(h_eff),
    .border(border_value), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_rdata),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_out(pixel_out),
    .end_of_row(end_of_row), .end_of_frame(end_of_frame)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> q_ready)
    else $error("queue push while full");

  a_eof_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!end_of_frame || end_of_row))
    else $error("end of frame without end of row");

  a_reset_idle: assert property (@(posedge clk) rst |=> (!out_valid && !q_valid))
    else $error("output or queue busy after reset");

endmodule

@@ tb/sv/box_blur_filter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_filter_checker
// Watches the configuration port and both item channels of the box blur
// filter, keeps its own model of the frame state and line store, predicts
// each blurred pixel and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module box_blur_filter_checker import bbf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              command,
  input  logic [PIX_W-1:0]  pixel_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [PIX_W-1:0]  pixel_out,
  input  logic              end_of_row,
  input  logic              end_of_frame,
  output int                fail_count,
  output int                pending
);

  localparam int STORE_W = DEF_MAX_WIDTH;
  localparam int STORE_H = DEF_MAX_WINDOW;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             eor;
    logic             eof;
  } blur_px_t;

  blur_px_t         blurred_q[$];
  logic [WS_W-1:0]  win_reg;
  logic [IW_W-1:0]  wid_reg;
  logic [IH_W-1:0]  hgt_reg;
  logic [PIX_W-1:0] border_reg;
  logic [PIX_W-1:0] rows [0:STORE_H*STORE_W-1];
  int               in_row, in_col, out_row, out_col;

  function automatic int win_eff();
    return (win_reg == 0) ? 1 : ((win_reg > STORE_H) ? STORE_H : int'(win_reg));
  endfunction

  function automatic int wid_eff();
    return (wid_reg == 0) ? 1 : ((wid_reg > STORE_W) ? STORE_W : int'(wid_reg));
  endfunction

  function automatic int hgt_eff();
    return (hgt_reg == 0) ? 1 : int'(hgt_reg);
  endfunction

  task automatic emit_blurred();
    int s, r, w, h, sum;
    blur_px_t e;
    s = win_eff();
    r = (s - 1) / 2;
    w = wid_eff();
    h = hgt_eff();
    sum = 0;
    for (int k = out_row - r; k <= out_row + r; k++)
      for (int l = out_col - r; l <= out_col + r; l++)
        if (k < 0 || l < 0 || k >= h || l >= w) sum += border_reg;
        else sum += rows[(k % STORE_H) * STORE_W + l];
    e.pix = 8'((sum / (s * s)) & 255);
    e.eor = (out_col + 1 >= w);
    e.eof = e.eor && (out_row + 1 >= h);
    blurred_q.insert(blurred_q.size(), e);
    if (e.eof) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end else if (e.eor) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  task automatic blur_step(input logic cmd, input logic [PIX_W-1:0] pix);
    int w, h, r, lin;
    w = wid_eff();
    h = hgt_eff();
    r = (win_eff() - 1) / 2;
    if (cmd == CMD_DRAIN || in_row >= h) begin
      if (in_row >= h && out_row < h) emit_blurred();
      return;
    end
    rows[(in_row % STORE_H) * STORE_W + in_col] = pix;
    lin = in_row * w + in_col;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (lin >= r * w + r) emit_blurred();
  endtask

  always @(posedge clk) begin
    blur_px_t e;
    if (rst) begin
      win_reg = RST_WINDOW;
      wid_reg = RST_WIDTH;
      hgt_reg = RST_HEIGHT;
      border_reg = RST_BORDER;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      blurred_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (blurred_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output item: pix=%0d eor=%0b eof=%0b",
                     pixel_out, end_of_row, end_of_frame);
        end else begin
          e = blurred_q.pop_front();
          if (e.pix !== pixel_out || e.eor !== end_of_row || e.eof !== end_of_frame) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp pix=%0d eor=%0b eof=%0b, got pix=%0d eor=%0b eof=%0b",
                       e.pix, e.eor, e.eof, pixel_out, end_of_row, end_of_frame);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: win_reg = cfg_data[WS_W-1:0];
          REG_WIDTH:  wid_reg = cfg_data[IW_W-1:0];
          REG_HEIGHT: hgt_reg = cfg_data[IH_W-1:0];
          REG_BORDER: border_reg = cfg_data[PIX_W-1:0];
          default: ;
        endcase
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end
      if (in_valid && in_ready) blur_step(command, pixel_in);
    end
    pending = blurred_q.size();
  end

endmodule

@@ tb/sv/box_blur_filter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_filter_tb
// Streams small frames through the box blur filter under many window, size
// and border settings with random idling on both channels and one long
// receiver stall; the checker predicts and compares every output item.
// ----------------------------------------------------------------------------
module box_blur_filter_tb;
  import bbf_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 600;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = CMD_PIXEL;
  logic [PIX_W-1:0]  pixel_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  pixel_out;
  logic              end_of_row;
  logic              end_of_frame;

  int fail_count, pending;
  int send_idle_pct = 23;
  int recv_idle_pct = 23;
  bit hold_request = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_blur_filter DUT (.*);

  box_blur_filter_checker u_checker (.*);

  always @(negedge clk) begin
    if (hold_request && !hold_done && in_valid) begin
      hold_left = 500;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[box_blur_filter] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    pixel_in = pix;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // pix_mode: 0 random, 1 all max, 2 all zero; full=0 sends a random prefix only
  task automatic run_frame(input int ws, input int w, input int h, input int border,
                           input int pix_mode, input bit full, input bit noise);
    int we, he, r, npix, tail;
    logic [PIX_W-1:0] p;
    settle();
    write_reg(REG_WINDOW, ws);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_BORDER, border);
    we = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
    he = (h == 0) ? 1 : h;
    ws = ws & 15;
    r = (((ws == 0) ? 1 : ws) - 1) / 2;
    npix = full ? we * he : $urandom_range(we * he - 1);
    for (int i = 0; i < npix; i++) begin
      if (noise && $urandom_range(99) < 10) send_item(CMD_DRAIN, 8'($urandom));
      p = (pix_mode == 1) ? 8'hff : ((pix_mode == 2) ? 8'h00 : 8'($urandom));
      send_item(CMD_PIXEL, p);
    end
    if (!full) return;
    tail = (r * we + r < we * he) ? r * we + r : we * he;
    for (int i = 0; i < tail; i++)
      send_item(noise && $urandom_range(3) == 0 ? CMD_PIXEL : CMD_DRAIN, 8'($urandom));
    if (noise) repeat ($urandom_range(2)) send_item(CMD_DRAIN, 8'($urandom));
  endtask

  initial begin
    int ws;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_frame(1, 1, 1, 0, 1, 1, 0);
    run_frame(0, 0, 0, 255, 2, 1, 1);
    run_frame(15, 3, 2, 255, 1, 1, 0);
    run_frame(2, 4, 2, 7, 0, 1, 1);
    run_frame(4, 2, 2, 200, 0, 1, 0);
    settle();
    write_reg(REG_HEIGHT, 8191);
    run_frame(3, 5, 3, 48, 0, 1, 1);

    while (items_sent < 1950) begin
      ws = ($urandom_range(9) < 7) ? $urandom_range(5) : $urandom_range(15);
      if (items_sent > 400 && items_sent < 700) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 23;
        recv_idle_pct = 23;
      end
      if (items_sent > 900 && items_sent < 1000) send_idle_pct = 0;
      hold_request = (items_sent > 900);
      if (items_sent > 1200 && items_sent < 1300)
        run_frame(1, 2047, 1, $urandom_range(255), 0, 1, 0);
      else
        run_frame(ws, $urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(255),
                  0, $urandom_range(99) >= 8, 1);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("[box_blur_filter] OK");
    end else begin
      $display("[box_blur_filter] ERROR");
    end
    $finish;
  end

endmodule

@@ box_blur_filter.f @@
rtl/core/bbf_pkg.sv
rtl/core/bbf_fifo.sv
rtl/core/bbf_front.sv
rtl/core/bbf_back.sv
rtl/core/box_blur_filter.sv
tb/sv/box_blur_filter_checker.sv
tb/sv/box_blur_filter_tb.sv
